// File: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the hue rotation core.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define RHR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Delayed implication: the consequent must hold after the delay given by n.
`define RHR_ASSERT_DLY(lbl, clk, rst_n, ante, n, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
		else $error("delayed implication check failed");

`endif

// File: rtl/core/rhr_pkg.sv
// ---------------------------------------------------------------------------
// rhr_pkg
// Types and constants shared by the hue rotation pipeline.
// ---------------------------------------------------------------------------
package rhr_pkg;

	localparam int HUE_FRAC_BITS_DEF = 6;

	localparam int CH_W      = 8;   // one color channel
	localparam int OFS_W     = 16;  // signed hue offset in degrees
	localparam int HUE_INT_W = 9;   // whole degrees, below 360
	localparam int NUM_W     = 11;  // hue numerator, below 6*255
	localparam int NUM60_W   = 17;  // numerator times 60, below 360*255

	// Offset reduction: bias to positive, then multiply by 2^25/360.
	localparam int XOFS_W    = 17;
	localparam int DEG_BIAS  = 33120;   // 92 * 360
	localparam int DEG_RECIP = 93207;   // ceil(2^25 / 360)
	localparam int DEG_SHIFT = 25;
	localparam int DEG_PROD_W = 34;
	localparam int DEG_Q_W   = 9;
	localparam int DEG_FULL  = 360;

	// Division by 60 of the scaled product: multiply by 2^20/60.
	localparam int Y_W       = 14;
	localparam int SEC_RECIP = 17477;   // ceil(2^20 / 60)
	localparam int SEC_SHIFT = 20;
	localparam int SEC_PROD_W = 29;
	localparam int SEC_DEG   = 60;

	localparam int DIV_BITS_PER_STG = 3;

	typedef struct packed {
		logic [CH_W-1:0]         red_in;
		logic [CH_W-1:0]         green_in;
		logic [CH_W-1:0]         blue_in;
		logic signed [OFS_W-1:0] hue_offset;
	} pix_in_t;

	typedef struct packed {
		logic [CH_W-1:0] red_out;
		logic [CH_W-1:0] green_out;
		logic [CH_W-1:0] blue_out;
	} pix_out_t;

	// Per-pixel data that rides alongside the hue division.
	typedef struct packed {
		logic [CH_W-1:0]      red;
		logic [CH_W-1:0]      green;
		logic [CH_W-1:0]      blue;
		logic [CH_W-1:0]      mx;
		logic [CH_W-1:0]      mn;
		logic [CH_W-1:0]      dl;
		logic [HUE_INT_W-1:0] dm;
		logic                 grey;
	} side_t;

endpackage

// File: rtl/core/rhr_front.sv
// ---------------------------------------------------------------------------
// rhr_front
// Max/min, hue numerator and offset reduction, three register stages.
// ---------------------------------------------------------------------------
module rhr_front
	import rhr_pkg::*;
#(
	parameter int HUE_FRAC_BITS = HUE_FRAC_BITS_DEF,
	localparam int DVD_W = NUM60_W + HUE_FRAC_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  pix_in_t          pix,
	output logic             out_valid,
	output side_t            side,
	output logic [DVD_W-1:0] dvd
);

	logic                 valid_s1, valid_s2, valid_s3;
	logic [CH_W-1:0]      r_s1, g_s1, b_s1, mx_s1, mn_s1, dl_s1;
	logic [NUM_W-1:0]     num_s1;
	logic [XOFS_W-1:0]    x_s1;
	logic [CH_W-1:0]      r_s2, g_s2, b_s2, mx_s2, mn_s2, dl_s2;
	logic [XOFS_W-1:0]    x_s2;
	logic [DEG_Q_W-1:0]   qd_s2;
	logic [DVD_W-1:0]     dvd_s2;
	side_t                side_s3;
	logic [DVD_W-1:0]     dvd_s3;

	logic [CH_W-1:0]      mx_c, mn_c;
	logic [NUM_W+0:0]     num_c;
	logic [DEG_PROD_W-1:0] degp_c;
	logic [NUM60_W-1:0]   num60_c;
	logic [XOFS_W-1:0]    dmx_c;

	// Stage 1: extremes and sector numerator.
	always_comb begin
		logic [NUM_W:0] dl12;
		dl12 = '0;
		mx_c = pix.red_in;
		mn_c = pix.red_in;
		if (pix.green_in > mx_c) mx_c = pix.green_in;
		if (pix.blue_in  > mx_c) mx_c = pix.blue_in;
		if (pix.green_in < mn_c) mn_c = pix.green_in;
		if (pix.blue_in  < mn_c) mn_c = pix.blue_in;
		dl12 = (NUM_W+1)'(mx_c - mn_c);
		if (pix.red_in == mx_c) begin
			if (pix.green_in >= pix.blue_in) begin
				num_c = (NUM_W+1)'(pix.green_in) - (NUM_W+1)'(pix.blue_in);
			end else begin
				num_c = dl12 * (NUM_W+1)'(6) - (NUM_W+1)'(pix.blue_in)
					+ (NUM_W+1)'(pix.green_in);
			end
		end else if (pix.green_in == mx_c) begin
			num_c = {dl12[NUM_W-1:0], 1'b0} + (NUM_W+1)'(pix.blue_in)
				- (NUM_W+1)'(pix.red_in);
		end else begin
			num_c = {dl12[NUM_W-2:0], 2'b00} + (NUM_W+1)'(pix.red_in)
				- (NUM_W+1)'(pix.green_in);
		end
	end

	// Stage 2: reciprocal multiply for the offset, numerator times 60.
	assign degp_c  = DEG_PROD_W'(x_s1) * DEG_PROD_W'(DEG_RECIP);
	assign num60_c = NUM60_W'(num_s1) * NUM60_W'(SEC_DEG);

	// Stage 3: remainder of the biased offset.
	assign dmx_c = x_s2 - XOFS_W'(qd_s2) * XOFS_W'(DEG_FULL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		r_s1   <= pix.red_in;
		g_s1   <= pix.green_in;
		b_s1   <= pix.blue_in;
		mx_s1  <= mx_c;
		mn_s1  <= mn_c;
		dl_s1  <= mx_c - mn_c;
		num_s1 <= num_c[NUM_W-1:0];
		x_s1   <= {pix.hue_offset[OFS_W-1], pix.hue_offset} + XOFS_W'(DEG_BIAS);

		r_s2   <= r_s1;
		g_s2   <= g_s1;
		b_s2   <= b_s1;
		mx_s2  <= mx_s1;
		mn_s2  <= mn_s1;
		dl_s2  <= dl_s1;
		x_s2   <= x_s1;
		qd_s2  <= degp_c[DEG_SHIFT+DEG_Q_W-1:DEG_SHIFT];
		dvd_s2 <= {num60_c, {HUE_FRAC_BITS{1'b0}}};

		side_s3.red   <= r_s2;
		side_s3.green <= g_s2;
		side_s3.blue  <= b_s2;
		side_s3.mx    <= mx_s2;
		side_s3.mn    <= mn_s2;
		side_s3.dl    <= dl_s2;
		side_s3.dm    <= dmx_c[HUE_INT_W-1:0];
		side_s3.grey  <= (dl_s2 == '0);
		dvd_s3        <= dvd_s2;
	end

	assign out_valid = valid_s3;
	assign side      = side_s3;
	assign dvd       = dvd_s3;

endmodule

// File: rtl/core/rhr_div.sv
// ---------------------------------------------------------------------------
// rhr_div
// Pipelined restoring divider: hue numerator over delta, three quotient bits a stage.
// ---------------------------------------------------------------------------
module rhr_div
	import rhr_pkg::*;
#(
	parameter int HUE_FRAC_BITS = HUE_FRAC_BITS_DEF,
	localparam int QW    = HUE_INT_W + HUE_FRAC_BITS,
	localparam int DVD_W = QW + CH_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  side_t            in_side,
	input  logic [DVD_W-1:0] dvd,
	output logic             out_valid,
	output side_t            out_side,
	output logic [QW-1:0]    quo
);

	localparam int BPS = DIV_BITS_PER_STG;
	localparam int NST = (QW + BPS - 1) / BPS;

	logic            vld_s  [NST];
	side_t           side_s [NST];
	logic [CH_W-1:0] rem_s  [NST];
	logic [QW-1:0]   low_s  [NST];
	logic [QW-1:0]   quo_s  [NST];

	genvar k;
	for (k = 0; k < NST; k++) begin : g_stg
		logic            v_i;
		side_t           sd_i;
		logic [CH_W-1:0] r_i, r_o;
		logic [QW-1:0]   l_i, l_o, q_i, q_o;

		if (k == 0) begin : g_head
			assign v_i  = in_valid;
			assign sd_i = in_side;
			// The upper byte is already below delta since the quotient fits QW bits.
			assign r_i  = dvd[DVD_W-1:QW];
			assign l_i  = dvd[QW-1:0];
			assign q_i  = '0;
		end else begin : g_body
			assign v_i  = vld_s[k-1];
			assign sd_i = side_s[k-1];
			assign r_i  = rem_s[k-1];
			assign l_i  = low_s[k-1];
			assign q_i  = quo_s[k-1];
		end

		always_comb begin
			logic [CH_W:0] trial;
			trial = '0;
			r_o   = r_i;
			l_o   = l_i;
			q_o   = q_i;
			for (int b = 0; b < BPS; b++) begin
				if (k * BPS + b < QW) begin
					trial = {r_o, l_o[QW-1]};
					l_o   = {l_o[QW-2:0], 1'b0};
					if (trial >= {1'b0, sd_i.dl}) begin
						r_o = CH_W'(trial - {1'b0, sd_i.dl});
						q_o = {q_o[QW-2:0], 1'b1};
					end else begin
						r_o = trial[CH_W-1:0];
						q_o = {q_o[QW-2:0], 1'b0};
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			side_s[k] <= sd_i;
			rem_s[k]  <= r_o;
			low_s[k]  <= l_o;
			quo_s[k]  <= q_o;
		end
	end

	assign out_valid = vld_s[NST-1];
	assign out_side  = side_s[NST-1];
	assign quo       = quo_s[NST-1];

endmodule

// File: rtl/core/rhr_back.sv
// ---------------------------------------------------------------------------
// rhr_back
// Rotate the hue, split sector and fraction, interpolate and rebuild RGB.
// ---------------------------------------------------------------------------
module rhr_back
	import rhr_pkg::*;
#(
	parameter int HUE_FRAC_BITS = HUE_FRAC_BITS_DEF,
	localparam int QW = HUE_INT_W + HUE_FRAC_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  side_t         side,
	input  logic [QW-1:0] quo,
	output logic          out_valid,
	output pix_out_t      result
);

	localparam int F      = HUE_FRAC_BITS;
	localparam int FULL   = DEG_FULL << F;
	localparam int FHI_W  = 6;
	localparam int FRAC_W = FHI_W + F;
	localparam int PROD_W = CH_W + FRAC_W;

	logic                 vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	side_t                side_s1, side_s2, side_s3, side_s4;
	logic [QW-1:0]        rot_s1;
	logic [2:0]           sec_s2, sec_s3, sec_s4;
	logic [FRAC_W-1:0]    frac_s2;
	logic [PROD_W-1:0]    prod_s3;
	logic [CH_W-1:0]      down_s4;
	logic [Y_W-1:0]       y_s4;
	logic                 lo_nz_s4;
	pix_out_t             result_s5;

	logic [QW:0]          sum_c;
	logic [QW-1:0]        rot_c;
	logic [HUE_INT_W-1:0] hi_c;
	logic [2:0]           sec_c;
	logic [HUE_INT_W-1:0] fhi_c;
	logic [Y_W-1:0]       y_c;
	logic [SEC_PROD_W-1:0] ym_c;
	logic [Y_W-1:0]       down60_c;
	logic [CH_W-1:0]      up_c, q_c, t_c;
	pix_out_t             pix_c;

	// Stage 1: add the offset and wrap once at the full circle.
	always_comb begin
		sum_c = {1'b0, quo} + {1'b0, side.dm, {F{1'b0}}};
		if (sum_c >= (QW+1)'(FULL)) begin
			rot_c = QW'(sum_c - (QW+1)'(FULL));
		end else begin
			rot_c = sum_c[QW-1:0];
		end
	end

	// Stage 2: sector from whole degrees, fraction keeps the low bits.
	always_comb begin
		hi_c  = rot_s1[QW-1:F];
		sec_c = '0;
		for (int i = 1; i < 6; i++) begin
			if (hi_c >= HUE_INT_W'(i * SEC_DEG)) sec_c = sec_c + 3'd1;
		end
		fhi_c = hi_c - HUE_INT_W'(sec_c) * HUE_INT_W'(SEC_DEG);
	end

	// Stage 4: divide the scaled product by 60 through its reciprocal.
	assign y_c  = prod_s3[PROD_W-1:F];
	assign ym_c = SEC_PROD_W'(y_c) * SEC_PROD_W'(SEC_RECIP);

	// Stage 5: round up where the division was inexact, then pick channels.
	always_comb begin
		down60_c = Y_W'(down_s4) * Y_W'(SEC_DEG);
		up_c     = down_s4 + ((y_s4 == down60_c && !lo_nz_s4) ? CH_W'(0) : CH_W'(1));
		q_c      = side_s4.mx - up_c;
		t_c      = side_s4.mn + down_s4;
		case (sec_s4)
			3'd0: pix_c = '{side_s4.mx, t_c, side_s4.mn};
			3'd1: pix_c = '{q_c, side_s4.mx, side_s4.mn};
			3'd2: pix_c = '{side_s4.mn, side_s4.mx, t_c};
			3'd3: pix_c = '{side_s4.mn, q_c, side_s4.mx};
			3'd4: pix_c = '{t_c, side_s4.mn, side_s4.mx};
			default: pix_c = '{side_s4.mx, side_s4.mn, q_c};
		endcase
		if (side_s4.grey) begin
			pix_c = '{side_s4.red, side_s4.green, side_s4.blue};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		side_s1  <= side;
		rot_s1   <= rot_c;

		side_s2  <= side_s1;
		sec_s2   <= sec_c;
		frac_s2  <= {fhi_c[FHI_W-1:0], rot_s1[F-1:0]};

		side_s3  <= side_s2;
		sec_s3   <= sec_s2;
		prod_s3  <= PROD_W'(side_s2.dl) * PROD_W'(frac_s2);

		side_s4  <= side_s3;
		sec_s4   <= sec_s3;
		down_s4  <= ym_c[SEC_SHIFT+CH_W-1:SEC_SHIFT];
		y_s4     <= y_c;
		lo_nz_s4 <= |prod_s3[F-1:0];

		result_s5 <= pix_c;
	end

	assign out_valid = vld_s5;
	assign result    = result_s5;

endmodule

// File: rtl/core/rgb_hue_rotation_top.sv
// ---------------------------------------------------------------------------
// rgb_hue_rotation_top
// HSV hue rotation of 8-bit RGB pixels, fully pipelined.
// ---------------------------------------------------------------------------
// Usage:
//   Input beat: drive pixel (three channels and a signed hue offset in whole
//   degrees) and raise start. The beat is taken at a rising edge where start
//   is high and busy is low. busy never rises, so a new pixel can be taken on
//   every clock.
//   Result beat: done is high for exactly one cycle while result holds the
//   rotated pixel. The receiver cannot hold results off, so there is no stall
//   path; results leave in the order pixels came in.
//   Path: a beat crosses the front end, the hue divider, which resolves
//   three quotient bits per stage, and the back end, with no stall between.
//   Throughput is one pixel per clock.
//   Grey pixels (all channels equal) leave unchanged whatever the offset.
//   Reset clears only the valid bits; the pipeline is empty afterward and
//   done stays low until a beat has crossed all stages.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rgb_hue_rotation_top
	import rhr_pkg::*;
#(
	parameter int HUE_FRAC_BITS = HUE_FRAC_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  pix_in_t  pixel,
	output logic     done,
	output pix_out_t result
);

	localparam int QW    = HUE_INT_W + HUE_FRAC_BITS;
	localparam int DVD_W = QW + CH_W;
	localparam int NST   = (QW + DIV_BITS_PER_STG - 1) / DIV_BITS_PER_STG;
	localparam int LAT   = 3 + NST + 5;

	logic             accept;
	logic             front_vld, div_vld;
	side_t            front_side, div_side;
	logic [DVD_W-1:0] dvd;
	logic [QW-1:0]    quo;
	logic             grey_in;

	// No stage ever waits, so the pipeline is always free to take a beat.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Front end: extremes, numerator, offset reduced to 0..359.
	rhr_front #(
		.HUE_FRAC_BITS(HUE_FRAC_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.pix       (pixel),
		.out_valid (front_vld),
		.side      (front_side),
		.dvd       (dvd)
	);

	// Hue divider: numerator * 60 * 2^F over delta.
	rhr_div #(
		.HUE_FRAC_BITS(HUE_FRAC_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_vld),
		.in_side   (front_side),
		.dvd       (dvd),
		.out_valid (div_vld),
		.out_side  (div_side),
		.quo       (quo)
	);

	// Back end: rotate, split into sector and fraction, rebuild the pixel.
	rhr_back #(
		.HUE_FRAC_BITS(HUE_FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (div_vld),
		.side      (div_side),
		.quo       (quo),
		.out_valid (done),
		.result    (result)
	);

	assign grey_in = (pixel.red_in == pixel.green_in) && (pixel.green_in == pixel.blue_in);

	// Every accepted beat leaves as a done pulse.
	`RHR_ASSERT_DLY(a_lat_fwd, clk, arst_n, accept, LAT, done)
	// No result without a matching accepted beat.
	`RHR_ASSERT_IMP(a_lat_back, clk, arst_n, done, $past(accept, LAT))
	// A grey pixel leaves as it came in.
	`RHR_ASSERT_IMP(a_grey_pass, clk, arst_n, done && $past(accept && grey_in, LAT),
		result.red_out == $past(pixel.red_in, LAT) && result.green_out == $past(pixel.green_in, LAT) && result.blue_out == $past(pixel.blue_in, LAT))

endmodule
